[hdl/stepper_angle_move_pulser_unit_assert.svh]
// assertion helpers, expect clk and rst_n in scope
`ifndef STEPPER_ANGLE_MOVE_PULSER_UNIT_ASSERT_SVH
`define STEPPER_ANGLE_MOVE_PULSER_UNIT_ASSERT_SVH

// same-cycle implication
`define SAMPU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sampu: same-cycle check failed");

// next-cycle implication
`define SAMPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sampu: next-cycle check failed");

`endif

[hdl/sampu_pkg.sv]
`timescale 1ns / 1ps

package sampu_pkg;

  localparam int DEF_DELAY_BITS = 20;
  localparam int DEF_SWEPT_BITS = 40;

  localparam logic [29:0] FULL_TURN = 30'd360000000;

  localparam logic [28:0] PER_STEP_RST   = 29'd1800000;
  localparam logic [19:0] STEP_DELAY_RST = 20'd1000;
  localparam logic [15:0] NEXT_STEPS_RST = 16'd8;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int IQ_DEPTH = 2;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);

  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // input kind codes
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_MOVE_ABS = 3'd1;
  localparam logic [2:0] KIND_MOVE_REL = 3'd2;
  localparam logic [2:0] KIND_NEXT     = 3'd3;
  localparam logic [2:0] KIND_HOME     = 3'd4;

  typedef enum logic [1:0] {
    CFG_PER_STEP   = 2'd0,
    CFG_STEP_DELAY = 2'd1,
    CFG_NEXT_STEPS = 2'd2,
    CFG_NEXT_CCW   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_MOVE_ABS,
    OP_MOVE_REL,
    OP_NEXT,
    OP_HOME,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] angle;
  } iq_entry_t;

  typedef struct packed {
    logic [28:0] per_step;
    logic [29:0] turn_add_cw;
    logic [29:0] turn_add_ccw;
    logic [15:0] next_steps;
    logic        next_ccw;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [28:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic               step_pin;
    logic               dir_pin;
    logic               busy;
    logic               rejected;
    logic [28:0]        angle;
    logic signed [31:0] step;
  } res_t;

endpackage

[hdl/stepper_angle_move_pulser_unit.sv]
`timescale 1ns / 1ps
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------------
// in_       | in        | push / full            | kind, angle_value
// out_      | out       | empty / pop            | step_pin, dir_pin, busy_res, rejected,
//           |           |                        | current_angle, current_step, angle_swept
// cfg_      | in        | valid / ready (ready=1)| index, wdata
//
// ticks, unknown kinds, next-move and rejected commands: done in ST_FETCH of the back end
// move to angle, move by delta, home: ST_DIFF and ST_DIV, on the 32-step serial divider
// a word passes the input queue, the back end and the output queue on its way to out_
// rst_n is synchronous; no memory needs a clearing pass, the block takes words right after
// a full output queue stalls the back end, which in turn fills the input queue
`include "stepper_angle_move_pulser_unit_assert.svh"

module stepper_angle_move_pulser_unit #(
  parameter int DELAY_BITS = sampu_pkg::DEF_DELAY_BITS,
  parameter int SWEPT_BITS = sampu_pkg::DEF_SWEPT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [2:0]             in_kind,
  input  logic signed [31:0]     in_angle_value,
  // result words
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic                   out_step_pin,
  output logic                   out_dir_pin,
  output logic                   out_busy_res,
  output logic                   out_rejected,
  output logic [28:0]            out_current_angle,
  output logic signed [31:0]     out_current_step,
  output logic [SWEPT_BITS-1:0]  out_angle_swept,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_wdata
);

  // pulse length cap follows the delay counter width
  localparam logic [31:0] DELAY_CAP = 32'((64'd1 << DELAY_BITS) - 64'd1);
  localparam logic [31:0] DELAY_RST =
      (32'(sampu_pkg::STEP_DELAY_RST) > DELAY_CAP) ? DELAY_CAP
                                                  : 32'(sampu_pkg::STEP_DELAY_RST);

  sampu_pkg::iq_entry_t   iq_head;
  logic                   iq_valid;
  logic                   iq_pop;
  sampu_pkg::div_req_t    div_req;
  sampu_pkg::div_rsp_t    div_rsp;
  logic                   oq_can_push;
  logic                   oq_push;
  sampu_pkg::res_t        oq_res_in;
  logic [SWEPT_BITS-1:0]  oq_swept_in;
  sampu_pkg::res_t        oq_res_out;

  // register file, with the derived step terms worked out at write time
  logic [28:0]            per_step_r;
  logic [29:0]            add_cw_r;
  logic [29:0]            add_ccw_r;
  logic [DELAY_BITS-1:0]  delay_load_r;
  logic [15:0]            next_steps_r;
  logic                   next_ccw_r;

  logic [28:0]            wr_per_step;
  logic [29:0]            wr_add_cw;
  logic [31:0]            wr_delay;
  logic                   cfg_we;
  sampu_pkg::cfg_t        cfg;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // zero angle per step counts as one
  assign wr_per_step = (cfg_wdata[28:0] == '0) ? 29'd1 : cfg_wdata[28:0];
  // angle per step reduced modulo one full turn
  assign wr_add_cw   = ({1'b0, wr_per_step} >= sampu_pkg::FULL_TURN)
                       ? {1'b0, wr_per_step} - sampu_pkg::FULL_TURN
                       : {1'b0, wr_per_step};
  // zero delay counts as one
  assign wr_delay    = (cfg_wdata[19:0] == '0) ? 32'd1 : {12'b0, cfg_wdata[19:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_step_r   <= sampu_pkg::PER_STEP_RST;
      add_cw_r     <= {1'b0, sampu_pkg::PER_STEP_RST};
      add_ccw_r    <= sampu_pkg::FULL_TURN - {1'b0, sampu_pkg::PER_STEP_RST};
      delay_load_r <= DELAY_RST[DELAY_BITS-1:0];
      next_steps_r <= sampu_pkg::NEXT_STEPS_RST;
      next_ccw_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sampu_pkg::CFG_PER_STEP: begin
          per_step_r <= wr_per_step;
          add_cw_r   <= wr_add_cw;
          add_ccw_r  <= sampu_pkg::FULL_TURN - wr_add_cw;
        end
        sampu_pkg::CFG_STEP_DELAY: begin
          delay_load_r <= (wr_delay > DELAY_CAP) ? DELAY_CAP[DELAY_BITS-1:0]
                                                 : wr_delay[DELAY_BITS-1:0];
        end
        sampu_pkg::CFG_NEXT_STEPS: begin
          next_steps_r <= cfg_wdata[15:0];
        end
        sampu_pkg::CFG_NEXT_CCW: begin
          next_ccw_r <= cfg_wdata[0];
        end
        default: begin
          next_ccw_r <= next_ccw_r;
        end
      endcase
    end
  end

  assign cfg.per_step     = per_step_r;
  assign cfg.turn_add_cw  = add_cw_r;
  assign cfg.turn_add_ccw = add_ccw_r;
  assign cfg.next_steps   = next_steps_r;
  assign cfg.next_ccw     = next_ccw_r;

  // front end: decode kind and buffer words
  sampu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .kind       (in_kind),
    .angle      (in_angle_value),
    .full       (in_full),
    .head       (iq_head),
    .head_valid (iq_valid),
    .pop        (iq_pop)
  );

  // shared serial divider for angle to step conversion
  sampu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back end: holds position state, runs ticks and commands in order
  sampu_back #(
    .DELAY_BITS (DELAY_BITS),
    .SWEPT_BITS (SWEPT_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (iq_head),
    .head_valid   (iq_valid),
    .head_pop     (iq_pop),
    .cfg          (cfg),
    .delay_load   (delay_load_r),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_can_push (oq_can_push),
    .out_push     (oq_push),
    .out_res      (oq_res_in),
    .out_swept    (oq_swept_in)
  );

  // result queue decouples the back end from the consumer
  sampu_outq #(
    .SWEPT_BITS (SWEPT_BITS)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .res_in    (oq_res_in),
    .swept_in  (oq_swept_in),
    .can_push  (oq_can_push),
    .pop       (out_pop),
    .empty     (out_empty),
    .res_out   (oq_res_out),
    .swept_out (out_angle_swept)
  );

  assign out_step_pin      = oq_res_out.step_pin;
  assign out_dir_pin       = oq_res_out.dir_pin;
  assign out_busy_res      = oq_res_out.busy;
  assign out_rejected      = oq_res_out.rejected;
  assign out_current_angle = oq_res_out.angle;
  assign out_current_step  = oq_res_out.step;

  // a rejected command leaves a move in flight
  `SAMPU_ASSERT_IMPLY(a_reject_busy, !out_empty && out_rejected, out_busy_res)
  // a high step pulse always belongs to an unfinished step
  `SAMPU_ASSERT_IMPLY(a_pulse_busy, !out_empty && out_step_pin, out_busy_res)
  // shown angle stays inside one turn
  `SAMPU_ASSERT_IMPLY(a_angle_wrap, !out_empty,
                      {1'b0, out_current_angle} < sampu_pkg::FULL_TURN)
  // a start request leaves the divider running, with done low
  `SAMPU_ASSERT_NEXT(a_div_start, div_req.start, !div_rsp.done)

endmodule

[hdl/sampu_front.sv]
`timescale 1ns / 1ps

module sampu_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [2:0]            kind,
  input  logic signed [31:0]    angle,
  output logic                  full,
  output sampu_pkg::iq_entry_t  head,
  output logic                  head_valid,
  input  logic                  pop
);

  sampu_pkg::iq_entry_t                 mem_r [sampu_pkg::IQ_DEPTH];
  logic [sampu_pkg::IQ_PTR_W-1:0]       wr_ptr_r;
  logic [sampu_pkg::IQ_PTR_W-1:0]       rd_ptr_r;
  logic [sampu_pkg::IQ_CNT_W-1:0]       cnt_r;
  sampu_pkg::op_t                       op;
  logic                                 do_push;
  logic                                 do_pop;

  always_comb begin
    unique case (kind)
      sampu_pkg::KIND_TICK:     op = sampu_pkg::OP_TICK;
      sampu_pkg::KIND_MOVE_ABS: op = sampu_pkg::OP_MOVE_ABS;
      sampu_pkg::KIND_MOVE_REL: op = sampu_pkg::OP_MOVE_REL;
      sampu_pkg::KIND_NEXT:     op = sampu_pkg::OP_NEXT;
      sampu_pkg::KIND_HOME:     op = sampu_pkg::OP_HOME;
      default:                  op = sampu_pkg::OP_NONE;
    endcase
  end

  assign full       = (cnt_r == sampu_pkg::IQ_CNT_W'(sampu_pkg::IQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= '{op: op, angle: angle};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[hdl/sampu_div.sv]
`timescale 1ns / 1ps

module sampu_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sampu_pkg::div_req_t  req,
  output sampu_pkg::div_rsp_t  rsp
);

  logic                              run_r;
  logic [sampu_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [28:0]                       rem_r;
  logic [31:0]                       quo_r;
  logic [28:0]                       dvs_r;
  logic [29:0]                       trial;
  logic [29:0]                       trial_sub;
  logic                              ge;

  // one restoring step per cycle, msb first
  assign trial     = {rem_r, quo_r[31]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign ge        = (trial >= {1'b0, dvs_r});

  assign rsp.done     = !run_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      run_r <= 1'b1;
      cnt_r <= sampu_pkg::DIV_CNT_W'(sampu_pkg::DIV_STEPS - 1);
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (run_r) begin
      rem_r <= ge ? trial_sub[28:0] : trial[28:0];
      quo_r <= {quo_r[30:0], ge};
    end
  end

endmodule

[hdl/sampu_outq.sv]
`timescale 1ns / 1ps

module sampu_outq #(
  parameter int SWEPT_BITS = sampu_pkg::DEF_SWEPT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sampu_pkg::res_t        res_in,
  input  logic [SWEPT_BITS-1:0]  swept_in,
  output logic                   can_push,
  input  logic                   pop,
  output logic                   empty,
  output sampu_pkg::res_t        res_out,
  output logic [SWEPT_BITS-1:0]  swept_out
);

  sampu_pkg::res_t                   res_mem_r   [sampu_pkg::OQ_DEPTH];
  logic [SWEPT_BITS-1:0]             swept_mem_r [sampu_pkg::OQ_DEPTH];
  logic [sampu_pkg::OQ_PTR_W-1:0]    wr_ptr_r;
  logic [sampu_pkg::OQ_PTR_W-1:0]    rd_ptr_r;
  logic [sampu_pkg::OQ_CNT_W-1:0]    cnt_r;
  logic                              do_push;
  logic                              do_pop;

  assign can_push  = (cnt_r != sampu_pkg::OQ_CNT_W'(sampu_pkg::OQ_DEPTH));
  assign empty     = (cnt_r == '0);
  assign res_out   = res_mem_r[rd_ptr_r];
  assign swept_out = swept_mem_r[rd_ptr_r];
  assign do_push   = push && can_push;
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      res_mem_r[wr_ptr_r]   <= res_in;
      swept_mem_r[wr_ptr_r] <= swept_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[hdl/sampu_back.sv]
`timescale 1ns / 1ps

module sampu_back #(
  parameter int DELAY_BITS = sampu_pkg::DEF_DELAY_BITS,
  parameter int SWEPT_BITS = sampu_pkg::DEF_SWEPT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sampu_pkg::iq_entry_t   head,
  input  logic                   head_valid,
  output logic                   head_pop,
  input  sampu_pkg::cfg_t        cfg,
  input  logic [DELAY_BITS-1:0]  delay_load,
  output sampu_pkg::div_req_t    div_req,
  input  sampu_pkg::div_rsp_t    div_rsp,
  input  logic                   out_can_push,
  output logic                   out_push,
  output sampu_pkg::res_t        out_res,
  output logic [SWEPT_BITS-1:0]  out_swept
);

  typedef enum logic [1:0] {
    ST_FETCH,
    ST_DIFF,
    ST_DIV
  } state_t;

  state_t                 st_r, st_nxt;
  logic [31:0]            steps_left_r, steps_left_nxt;
  logic                   ccw_r, ccw_nxt;
  logic                   pulse_r, pulse_nxt;
  logic [DELAY_BITS-1:0]  delay_r, delay_nxt;
  logic [28:0]            angle_r, angle_nxt;
  logic signed [31:0]     net_r, net_nxt;
  logic [SWEPT_BITS-1:0]  swept_r, swept_nxt;
  logic                   clr_r, clr_nxt;
  logic signed [33:0]     diff_r, diff_nxt;
  logic                   home_r, home_nxt;

  logic                   busy;
  logic                   rejected;
  logic [29:0]            ang_sum;
  logic [29:0]            ang_wrap;
  logic [SWEPT_BITS:0]    swept_sum;
  logic [SWEPT_BITS-1:0]  swept_sat;
  logic [33:0]            mag_wide;
  logic signed [33:0]     target;
  logic [33:0]            base;
  logic [31:0]            quot;

  assign busy = (steps_left_r != '0);

  // wrapped angle after one step, add terms are already no more than one turn
  assign ang_sum  = {1'b0, angle_r} + (ccw_r ? cfg.turn_add_ccw : cfg.turn_add_cw);
  assign ang_wrap = (ang_sum >= sampu_pkg::FULL_TURN) ? ang_sum - sampu_pkg::FULL_TURN
                                                      : ang_sum;

  assign swept_sum = {1'b0, swept_r} + (SWEPT_BITS + 1)'(cfg.per_step);
  assign swept_sat = swept_sum[SWEPT_BITS] ? '1 : swept_sum[SWEPT_BITS-1:0];

  // home is a move to angle zero
  assign target   = (head.op == sampu_pkg::OP_HOME) ? '0 : 34'(head.angle);
  assign base     = (head.op == sampu_pkg::OP_MOVE_REL) ? '0 : {5'b0, angle_r};
  assign mag_wide = diff_r[33] ? 34'(-diff_r) : 34'(diff_r);
  assign quot     = div_rsp.quotient;

  always_comb begin
    st_nxt         = st_r;
    steps_left_nxt = steps_left_r;
    ccw_nxt        = ccw_r;
    pulse_nxt      = pulse_r;
    delay_nxt      = delay_r;
    angle_nxt      = angle_r;
    net_nxt        = net_r;
    swept_nxt      = swept_r;
    clr_nxt        = clr_r;
    diff_nxt       = diff_r;
    home_nxt       = home_r;
    head_pop       = 1'b0;
    out_push       = 1'b0;
    rejected       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mag_wide[31:0];
    div_req.divisor  = cfg.per_step;

    unique case (st_r)
      ST_FETCH: begin
        if (head_valid && out_can_push) begin
          head_pop = 1'b1;
          priority if (head.op == sampu_pkg::OP_NONE) begin
            out_push = 1'b1;
          end else if (head.op == sampu_pkg::OP_TICK) begin
            out_push = 1'b1;
            if (pulse_r) begin
              if (delay_r != '0) begin
                delay_nxt = delay_r - 1'b1;
              end
              if (delay_r <= DELAY_BITS'(1)) begin
                pulse_nxt      = 1'b0;
                angle_nxt      = ang_wrap[28:0];
                net_nxt        = ccw_r ? net_r - 32'sd1 : net_r + 32'sd1;
                swept_nxt      = swept_sat;
                steps_left_nxt = steps_left_r - 32'd1;
                if (steps_left_r == 32'd1 && clr_r) begin
                  swept_nxt = '0;
                  clr_nxt   = 1'b0;
                end
              end
            end else if (busy) begin
              delay_nxt = delay_load;
              pulse_nxt = 1'b1;
            end
          end else if (busy) begin
            rejected = 1'b1;
            out_push = 1'b1;
          end else if (head.op == sampu_pkg::OP_NEXT) begin
            out_push       = 1'b1;
            steps_left_nxt = {16'b0, cfg.next_steps};
            ccw_nxt        = cfg.next_ccw && (cfg.next_steps != '0);
          end else begin
            diff_nxt = target - $signed(base);
            home_nxt = (head.op == sampu_pkg::OP_HOME);
            st_nxt   = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        div_req.start = 1'b1;
        st_nxt        = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done && out_can_push) begin
          out_push       = 1'b1;
          steps_left_nxt = quot;
          ccw_nxt        = diff_r[33] && (quot != '0);
          if (home_r) begin
            if (quot == '0) begin
              swept_nxt = '0;
              clr_nxt   = 1'b0;
            end else begin
              clr_nxt = 1'b1;
            end
          end
          st_nxt = ST_FETCH;
        end
      end
      default: begin
        st_nxt = ST_FETCH;
      end
    endcase

    out_res.step_pin = pulse_nxt;
    out_res.dir_pin  = ccw_nxt;
    out_res.busy     = (steps_left_nxt != '0);
    out_res.rejected = rejected;
    out_res.angle    = angle_nxt;
    out_res.step     = net_nxt;
    out_swept        = swept_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_FETCH;
      steps_left_r <= '0;
      ccw_r        <= 1'b0;
      pulse_r      <= 1'b0;
      delay_r      <= '0;
      angle_r      <= '0;
      net_r        <= '0;
      swept_r      <= '0;
      clr_r        <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      steps_left_r <= steps_left_nxt;
      ccw_r        <= ccw_nxt;
      pulse_r      <= pulse_nxt;
      delay_r      <= delay_nxt;
      angle_r      <= angle_nxt;
      net_r        <= net_nxt;
      swept_r      <= swept_nxt;
      clr_r        <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    home_r <= home_nxt;
  end

endmodule

[tb/stepper_angle_move_pulser_unit_test.sv]
`timescale 1ns / 1ps

module stepper_angle_move_pulser_unit_test;

  localparam int SWEPT_W = sampu_pkg::DEF_SWEPT_BITS;
  localparam logic [63:0] SWEPT_MAX = (64'd1 << SWEPT_W) - 64'd1;
  localparam longint TURN_UDEG = 64'sd360000000;
  localparam longint ANGLE_MIN = -64'sd2147483648;
  localparam longint ANGLE_MAX = 64'sd2147483647;

  // kinds past home carry no command
  localparam logic [2:0] KIND_UNKNOWN_LO = sampu_pkg::KIND_HOME + 3'd1;
  localparam logic [2:0] KIND_UNKNOWN_HI = 3'd7;

  localparam int QUIET_CYCLES = 40;      // longer than a divider pass
  localparam int HOLD_CYCLES = 90;       // long receiver hold-off
  localparam int ROUND_WORDS = 70;
  localparam int ROUNDS = 6;
  localparam longint TIMEOUT_NS = 64'd60_000_000;

  // one result word as the block shows it
  typedef struct packed {
    logic               step_pin;
    logic               dir_pin;
    logic               busy;
    logic               rejected;
    logic [28:0]        angle;
    logic [31:0]        net;
    logic [SWEPT_W-1:0] swept;
  } report_t;

  // shadow copy of the motor bookkeeping plus the words still owed by the block
  class motion_book;
    logic [28:0]        per_step_reg;
    logic [19:0]        delay_reg;
    logic [15:0]        next_steps_reg;
    logic               next_ccw_reg;
    logic [31:0]        steps_left;
    logic               moving_ccw;
    logic               pulse_high;
    logic [19:0]        delay_count;
    logic [28:0]        shaft;
    logic [31:0]        net_steps;
    logic [SWEPT_W-1:0] swept;
    logic               clear_on_done;
    report_t            owed[$];
    int unsigned        faults, compared, turned_away, steps_done, saturations;

    function new();
      per_step_reg = sampu_pkg::PER_STEP_RST;
      delay_reg = sampu_pkg::STEP_DELAY_RST;
      next_steps_reg = sampu_pkg::NEXT_STEPS_RST;
      next_ccw_reg = 1'b0;
      steps_left = '0;
      moving_ccw = 1'b0;
      pulse_high = 1'b0;
      delay_count = '0;
      shaft = '0;
      net_steps = '0;
      swept = '0;
      clear_on_done = 1'b0;
      faults = 0;
      compared = 0;
      turned_away = 0;
      steps_done = 0;
      saturations = 0;
    endfunction

    function void set_reg(sampu_pkg::cfg_idx_t idx, logic [31:0] val);
      case (idx)
        sampu_pkg::CFG_PER_STEP:   per_step_reg = val[28:0];
        sampu_pkg::CFG_STEP_DELAY: delay_reg = val[19:0];
        sampu_pkg::CFG_NEXT_STEPS: next_steps_reg = val[15:0];
        sampu_pkg::CFG_NEXT_CCW:   next_ccw_reg = val[0];
        default: ;
      endcase
    endfunction

    // zero angle per step behaves as one
    function logic [63:0] eff_step();
      return (per_step_reg == '0) ? 64'd1 : 64'(per_step_reg);
    endfunction

    function void latch_move(bit neg, logic [63:0] mag);
      logic [63:0] q;
      q = mag / eff_step();
      steps_left = q[31:0];
      moving_ccw = neg && (q != 64'd0);
    endfunction

    function void head_to(longint target);
      longint diff;
      diff = target - longint'(shaft);
      if (diff < 0) latch_move(1'b1, 64'(-diff));
      else latch_move(1'b0, 64'(diff));
    endfunction

    function void book_step();
      logic [63:0] p, pm;
      p = eff_step();
      pm = p % 64'(TURN_UDEG);
      // angle wraps at one full turn in both directions
      if (moving_ccw) begin
        shaft = 29'((64'(shaft) + 64'(TURN_UDEG) - pm) % 64'(TURN_UDEG));
        net_steps = net_steps - 32'd1;
      end else begin
        shaft = 29'((64'(shaft) + pm) % 64'(TURN_UDEG));
        net_steps = net_steps + 32'd1;
      end
      if (64'(swept) >= SWEPT_MAX || SWEPT_MAX - 64'(swept) < p) begin
        swept = SWEPT_W'(SWEPT_MAX);
        saturations++;
      end else begin
        swept = SWEPT_W'(64'(swept) + p);
      end
      steps_left = steps_left - 32'd1;
      steps_done++;
      if (steps_left == '0 && clear_on_done) begin
        swept = '0;
        clear_on_done = 1'b0;
      end
    endfunction

    function void tick();
      if (pulse_high) begin
        if (delay_count != '0) delay_count = delay_count - 20'd1;
        if (delay_count == '0) begin
          pulse_high = 1'b0;
          book_step();
        end
      end else if (steps_left != '0) begin
        delay_count = (delay_reg == '0) ? 20'd1 : delay_reg;
        pulse_high = 1'b1;
      end
    endfunction

    // accepted input word: advance the state and queue the word it must produce
    function void take_word(logic [2:0] kind, logic signed [31:0] angle);
      report_t r;
      bit      rej;
      longint  a;
      rej = 1'b0;
      a = longint'(angle);
      if (kind == sampu_pkg::KIND_TICK) begin
        tick();
      end else if (kind <= sampu_pkg::KIND_HOME) begin
        if (steps_left != '0) begin
          rej = 1'b1;
          turned_away++;
        end else begin
          case (kind)
            sampu_pkg::KIND_MOVE_ABS: head_to(a);
            sampu_pkg::KIND_MOVE_REL: begin
              if (a < 0) latch_move(1'b1, 64'(-a));
              else latch_move(1'b0, 64'(a));
            end
            sampu_pkg::KIND_NEXT: begin
              steps_left = 32'(next_steps_reg);
              moving_ccw = next_ccw_reg && (next_steps_reg != '0);
            end
            default: begin
              head_to(0);
              if (steps_left == '0) begin
                swept = '0;
                clear_on_done = 1'b0;
              end else begin
                clear_on_done = 1'b1;
              end
            end
          endcase
        end
      end
      r.step_pin = pulse_high;
      r.dir_pin = moving_ccw;
      r.busy = (steps_left != '0);
      r.rejected = rej;
      r.angle = shaft;
      r.net = net_steps;
      r.swept = swept;
      owed.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        faults++;
      end
    endfunction

    function void check_word(report_t got);
      report_t want;
      if (owed.size() == 0) begin
        $error("result word with nothing pending");
        faults++;
        return;
      end
      want = owed.pop_front();
      compared++;
      cmp("step_pin", 64'(want.step_pin), 64'(got.step_pin));
      cmp("dir_pin", 64'(want.dir_pin), 64'(got.dir_pin));
      cmp("busy_res", 64'(want.busy), 64'(got.busy));
      cmp("rejected", 64'(want.rejected), 64'(got.rejected));
      cmp("current_angle", 64'(want.angle), 64'(got.angle));
      cmp("current_step", 64'(want.net), 64'(got.net));
      cmp("angle_swept", 64'(want.swept), 64'(got.swept));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [2:0]            in_kind;
  logic signed [31:0]    in_angle_value;
  logic                  out_empty;
  logic                  out_pop;
  logic                  out_step_pin;
  logic                  out_dir_pin;
  logic                  out_busy_res;
  logic                  out_rejected;
  logic [28:0]           out_current_angle;
  logic signed [31:0]    out_current_step;
  logic [SWEPT_W-1:0]    out_angle_swept;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [31:0]           cfg_wdata;

  motion_book  motion;
  bit          backlog_req;     // asks the receiver for one long hold-off
  int unsigned burst_left;
  int unsigned words_sent;
  int unsigned settings_used;

  stepper_angle_move_pulser_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_angle_value    (in_angle_value),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_step_pin      (out_step_pin),
    .out_dir_pin       (out_dir_pin),
    .out_busy_res      (out_busy_res),
    .out_rejected      (out_rejected),
    .out_current_angle (out_current_angle),
    .out_current_step  (out_current_step),
    .out_angle_swept   (out_angle_swept),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT_NS);
    $display("stepper_angle_move_pulser_unit: mismatch");
    $finish;
  end

  // every popped word is checked against the oldest owed word
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      motion.check_word({out_step_pin, out_dir_pin, out_busy_res, out_rejected,
                         out_current_angle, out_current_step, out_angle_swept});
  end

  // receiver: pop pattern changes after each run of random length, plus one long hold-off
  initial begin
    int unsigned mode, left;
    mode = 0;
    left = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (backlog_req) begin
        backlog_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: out_pop <= 1'b1;                           // always taking words
        1: out_pop <= 1'($urandom_range(0, 1));
        2: out_pop <= ((left % 8) < 4);               // alternating equal runs of pops and pauses
        default: out_pop <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // sender: bursts of random length separated by random gaps
  task automatic push_word(logic [2:0] kind, logic signed [31:0] angle);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_push <= 1'b1;
    in_kind <= kind;
    in_angle_value <= angle;
    do @(posedge clk); while (in_full);
    motion.take_word(kind, angle);
    words_sent++;
  endtask

  // at most max_q steps (40 for home) unless the step is so coarse that any angle is cheap
  task automatic push_command(int unsigned max_q);
    logic [2:0]         kind;
    logic signed [31:0] word_angle;
    longint             p, mag, a;
    p = longint'(motion.eff_step());
    kind = 3'($urandom_range(sampu_pkg::KIND_MOVE_ABS, sampu_pkg::KIND_HOME));
    // homing from far away with a fine step would take forever
    if (kind == sampu_pkg::KIND_HOME && motion.steps_left == '0 &&
        longint'(motion.shaft) / p > 40)
      kind = sampu_pkg::KIND_MOVE_ABS;
    if (p >= 100000000 && $urandom_range(0, 3) == 0) begin
      word_angle = $urandom;
    end else begin
      mag = longint'($urandom_range(0, max_q)) * p + longint'($urandom_range(0, 32'(p - 1)));
      a = $urandom_range(0, 1) ? -mag : mag;
      if (kind == sampu_pkg::KIND_MOVE_ABS) a = a + longint'(motion.shaft);
      if (a > ANGLE_MAX) a = ANGLE_MAX;
      if (a < ANGLE_MIN) a = ANGLE_MIN;
      word_angle = 32'(a);
    end
    push_word(kind, word_angle);
  endtask

  task automatic tick_until_still();
    while (motion.steps_left != '0)
      push_word(sampu_pkg::KIND_TICK, $urandom);
  endtask

  // stop offering, let every owed word come back, then give the divider time
  task automatic wait_quiet();
    @(negedge clk);
    in_push <= 1'b0;
    while (motion.owed.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(sampu_pkg::cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    motion.set_reg(idx, val);
  endtask

  task automatic load_settings(logic [28:0] p, logic [19:0] d, logic [15:0] n, logic c);
    wait_quiet();
    write_reg(sampu_pkg::CFG_PER_STEP, 32'(p));
    write_reg(sampu_pkg::CFG_STEP_DELAY, 32'(d));
    write_reg(sampu_pkg::CFG_NEXT_STEPS, 32'(n));
    write_reg(sampu_pkg::CFG_NEXT_CCW, 32'(c));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [28:0] p;
    logic [19:0] d;
    int unsigned r;
    motion = new();
    backlog_req = 1'b0;
    burst_left = 0;
    words_sent = 0;
    settings_used = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_kind = sampu_pkg::KIND_TICK;
    in_angle_value = '0;
    cfg_valid = 1'b0;
    cfg_index = sampu_pkg::CFG_PER_STEP;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: idle tick, unknown kinds, zero-step commands
    push_word(sampu_pkg::KIND_TICK, 0);
    for (int k = KIND_UNKNOWN_LO; k <= KIND_UNKNOWN_HI; k++)
      push_word(3'(k), $urandom);
    push_word(sampu_pkg::KIND_HOME, 0);
    push_word(sampu_pkg::KIND_MOVE_REL, 0);
    push_word(sampu_pkg::KIND_MOVE_REL, -1);  // less than a step back: zero count, clockwise
    push_word(sampu_pkg::KIND_MOVE_ABS, 0);
    // short pulses so a single step takes only a few ticks
    load_settings(29'd1800000, 20'd2, 16'd8, 1'b0);
    // one step, then every command kind while it runs is turned away
    push_word(sampu_pkg::KIND_MOVE_REL, 1800000);
    push_word(sampu_pkg::KIND_TICK, 0);
    push_word(sampu_pkg::KIND_MOVE_ABS, 5);
    push_word(sampu_pkg::KIND_MOVE_REL, -5);
    push_word(sampu_pkg::KIND_NEXT, 0);
    push_word(sampu_pkg::KIND_HOME, 0);
    tick_until_still();
    // homing with one step left: swept total clears on the last step
    push_word(sampu_pkg::KIND_HOME, 0);
    tick_until_still();

    // finest step, shortest pulse, zero-count next move asking for ccw
    load_settings(29'd1, 20'd1, 16'd0, 1'b1);
    push_word(sampu_pkg::KIND_NEXT, 0);
    push_word(sampu_pkg::KIND_MOVE_REL, -3);  // wraps below zero
    tick_until_still();
    push_word(sampu_pkg::KIND_MOVE_REL, 5);   // wraps past a full turn
    tick_until_still();

    // zero step angle and zero delay both behave as one
    load_settings(29'd0, 20'd0, 16'd5, 1'b1);
    push_word(sampu_pkg::KIND_NEXT, 0);
    tick_until_still();

    // a full turn per step: angle extremes give only a few steps
    load_settings(29'd360000000, 20'd2, 16'd0, 1'b0);
    push_word(sampu_pkg::KIND_MOVE_REL, 32'sh8000_0000);
    tick_until_still();
    push_word(sampu_pkg::KIND_MOVE_REL, 32'sh7fff_ffff);
    tick_until_still();
    push_word(sampu_pkg::KIND_MOVE_ABS, 32'sh8000_0000);
    tick_until_still();
    push_word(sampu_pkg::KIND_MOVE_ABS, 32'sh7fff_ffff);
    tick_until_still();
    push_word(sampu_pkg::KIND_HOME, 0);       // no steps: swept clears at once

    // widest step angle: each step is over a full turn, then homing clears the swept total
    load_settings(29'h1fff_ffff, 20'd1, 16'd50, 1'b0);
    push_word(sampu_pkg::KIND_NEXT, 0);
    tick_until_still();
    push_word(sampu_pkg::KIND_HOME, 0);

    // random settings, mostly commands followed by ticks, with noise
    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      case ($urandom_range(0, 6))
        0: p = 29'd1;
        1: p = 29'd1800000;
        2: p = 29'($urandom_range(2, 5000));
        3: p = 29'd360000000;
        4: p = 29'h1fff_ffff;
        5: p = 29'($urandom);
        default: p = 29'd0;
      endcase
      d = ($urandom_range(0, 9) == 0) ? 20'd0 : 20'($urandom_range(1, 4));
      load_settings(p, d, 16'($urandom_range(0, 12)), 1'($urandom_range(0, 1)));
      // receiver stops for a while so the block backs up into its input
      if (rnd == 1) backlog_req = 1'b1;
      for (int i = 0; i < ROUND_WORDS; i++) begin
        if (motion.steps_left == '0) begin
          r = $urandom_range(0, 9);
          if (r <= 3) push_command(($urandom_range(0, 9) == 0) ? 40 : 6);
          else if (r == 4)
            push_word(3'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI)), $urandom);
          else push_word(sampu_pkg::KIND_TICK, $urandom);
        end else begin
          r = $urandom_range(0, 19);
          if (r == 0)
            push_word(3'($urandom_range(sampu_pkg::KIND_MOVE_ABS, sampu_pkg::KIND_HOME)),
                      $urandom);
          else if (r == 1)
            push_word(3'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI)), $urandom);
          else push_word(sampu_pkg::KIND_TICK, $urandom);
        end
      end
      tick_until_still();
    end

    // widest delay and next-move count: start the move, a few ticks, turned-away commands
    load_settings(29'd1800000, 20'hf_ffff, 16'hffff, 1'b1);
    push_word(sampu_pkg::KIND_NEXT, 0);
    repeat (4) push_word(sampu_pkg::KIND_TICK, $urandom);
    push_word(sampu_pkg::KIND_MOVE_REL, $urandom);
    push_word(sampu_pkg::KIND_HOME, 0);

    wait_quiet();
    $display("sent %0d words over %0d register settings, %0d commands turned away",
             words_sent, settings_used, motion.turned_away);
    $display("%0d steps booked, swept total saturated %0d times, %0d results compared",
             motion.steps_done, motion.saturations, motion.compared);
    if (motion.faults == 0 && motion.owed.size() == 0) begin
      $display("stepper_angle_move_pulser_unit: match");
    end else begin
      $display("stepper_angle_move_pulser_unit: mismatch");
    end
    $finish;
  end

endmodule
